// ===== rtl/assert_macros.svh =====
// assertion macros used by the min_heap_priority_queue rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: expr");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");

`endif

// ===== rtl/hpq_pkg.sv =====
// shared types and constants for the min-heap priority queue
// no dependencies
package hpq_pkg;

    localparam int HPQ_CAPACITY   = 128;
    localparam int HPQ_DATA_WIDTH = 32;

    // external field widths
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 8;

    typedef enum logic {
        CMD_INSERT  = 1'b0,
        CMD_EXTRACT = 1'b1
    } hpq_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } hpq_status_t;

    // per-cycle operation broadcast to every cell
    typedef struct packed {
        logic ins;
        logic ext;
    } hpq_ctrl_t;

    // status a cell hands to its neighbors
    typedef struct packed {
        logic valid;
        logic keep;
    } hpq_link_t;

endpackage

// ===== rtl/hpq_cell.sv =====
// one cell of the sorted queue chain: holds a single entry
// depends on hpq_pkg
module hpq_cell import hpq_pkg::*; #(
    parameter int DATA_WIDTH = HPQ_DATA_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hpq_ctrl_t             ctrl,
    input  logic [DATA_WIDTH-1:0] new_value,
    input  logic [DATA_WIDTH-1:0] left_value,
    input  hpq_link_t             left_link,
    input  logic [DATA_WIDTH-1:0] right_value,
    input  logic                  right_valid,
    output logic [DATA_WIDTH-1:0] cell_value,
    output hpq_link_t             cell_link
);

    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic                  valid_reg, valid_next;
    logic                  keep;

    // entry stays put when it is not greater than the new value
    assign keep = valid_reg && ($signed(val_reg) <= $signed(new_value));

    always_comb begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (ctrl.ext) begin
            val_next   = right_value;
            valid_next = right_valid;
        end else if (ctrl.ins && !keep) begin
            if (left_link.keep) begin
                val_next   = new_value;
                valid_next = 1'b1;
            end else begin
                // shift one place toward the tail
                val_next   = left_value;
                valid_next = left_link.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign cell_value      = val_reg;
    assign cell_link.valid = valid_reg;
    assign cell_link.keep  = keep;

endmodule

// ===== rtl/min_heap_priority_queue.sv =====
// Priority queue of signed values kept as a sorted chain of CAPACITY cells, smallest at the
// head. An insert compares the value against all cells at once and the larger entries step
// one cell toward the tail; an extract takes the head and every entry steps one cell toward
// the head. The result is registered and shows in the cycle after the request is accepted;
// a new request is taken in the same cycle that the previous result is taken, so a stream of
// one request per cycle is sustained while the receiver keeps m_tready high. The cell
// comparators on the broadcast value set the clock. Insert into a full queue reports full and
// changes nothing; extract from an empty queue reports empty with value 0.
// depends on hpq_pkg, hpq_cell, assert_macros.svh
`include "assert_macros.svh"

module min_heap_priority_queue import hpq_pkg::*; #(
    parameter int CAPACITY   = HPQ_CAPACITY,
    parameter int DATA_WIDTH = HPQ_DATA_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] result_value, [39:32] occupancy
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                  accept;
    hpq_cmd_t              cmd;
    hpq_ctrl_t             ctrl;
    logic [DATA_WIDTH-1:0] new_value;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  full, empty;

    logic [DATA_WIDTH-1:0] chain_value [CAPACITY+2];
    hpq_link_t             chain_link  [CAPACITY+2];

    logic                  m_valid_reg;
    logic [VALUE_W-1:0]    res_value_reg, res_value_next;
    hpq_status_t           status_reg, status_next;
    logic [OCC_W-1:0]      occ_reg;

    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cmd       = hpq_cmd_t'(s_tuser);
    assign new_value = DATA_WIDTH'(signed'(s_tdata[VALUE_W-1:0]));

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    assign ctrl.ins = accept && (cmd == CMD_INSERT) && !full;
    assign ctrl.ext = accept && (cmd == CMD_EXTRACT) && !empty;

    // virtual head in front of the first cell, empty tail behind the last
    assign chain_value[0]                = '0;
    assign chain_link[0].valid           = 1'b1;
    assign chain_link[0].keep            = 1'b1;
    assign chain_value[CAPACITY+1]       = '0;
    assign chain_link[CAPACITY+1].valid  = 1'b0;
    assign chain_link[CAPACITY+1].keep   = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        hpq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .new_value   (new_value),
            .left_value  (chain_value[i]),
            .left_link   (chain_link[i]),
            .right_value (chain_value[i+2]),
            .right_valid (chain_link[i+2].valid),
            .cell_value  (chain_value[i+1]),
            .cell_link   (chain_link[i+1])
        );
    end

    always_comb begin
        count_next     = count_reg;
        res_value_next = '0;
        status_next    = STATUS_OK;
        if (cmd == CMD_INSERT) begin
            if (full) begin
                status_next = STATUS_FULL;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end else begin
            if (empty) begin
                status_next = STATUS_EMPTY;
            end else begin
                count_next     = count_reg - CNT_W'(1);
                res_value_next = VALUE_W'(signed'(chain_value[1]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_value_reg <= res_value_next;
            status_reg    <= status_next;
            occ_reg       <= OCC_W'(count_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {occ_reg, res_value_reg};
    assign m_tuser  = status_reg;

    // head cell holds an entry exactly when the queue is not empty
    `ASSERT_ALWAYS(a_head_matches_count, aclk, aresetn, chain_link[1].valid == !empty)
    `ASSERT_ALWAYS(a_count_bounded, aclk, aresetn, count_reg <= CNT_W'(CAPACITY))
    `ASSERT_NEXT(a_insert_grows, aclk, aresetn, ctrl.ins,
        count_reg == $past(count_reg) + CNT_W'(1))
    `ASSERT_NEXT(a_accept_gives_result, aclk, aresetn, accept, m_valid_reg)

endmodule

// ===== dv/hpq_result_checker.sv =====
// result checker for the min-heap priority queue: watches both stream channels,
// keeps its own heap to predict each result and compares the results field by field
// depends on hpq_pkg
module hpq_result_checker import hpq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] value
    input  logic        s_tuser,    // [0] command
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,    // [31:0] result_value, [39:32] occupancy
    input  logic [1:0]  m_tuser,    // [1:0] status
    output int          mismatch_count,
    output int          outstanding
);

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        hpq_status_t               status;
        logic [OCC_W-1:0]          occupancy;
    } hpq_result_t;

    logic signed [VALUE_W-1:0] heap_mem [1:HPQ_CAPACITY];
    int unsigned               heap_size = 0;
    hpq_result_t               awaited_q[$];
    int                        fail_tally = 0;

    // applies one request to the heap and returns the result it should produce
    function automatic hpq_result_t apply_request(hpq_cmd_t cmd, logic signed [VALUE_W-1:0] val);
        hpq_result_t               res;
        int unsigned               pos;
        int unsigned               best;
        logic signed [VALUE_W-1:0] tmp;
        bit                        settled;
        res.value  = '0;
        res.status = STATUS_OK;
        if (cmd == CMD_INSERT) begin
            if (heap_size >= HPQ_CAPACITY) begin
                res.status = STATUS_FULL;
            end else begin
                heap_size++;
                pos = heap_size;
                heap_mem[pos] = val;
                // climb only past strictly greater parents
                while (pos > 1 && heap_mem[pos / 2] > heap_mem[pos]) begin
                    tmp                = heap_mem[pos / 2];
                    heap_mem[pos / 2] = heap_mem[pos];
                    heap_mem[pos]      = tmp;
                    pos                = pos / 2;
                end
            end
        end else if (heap_size == 0) begin
            res.status = STATUS_EMPTY;
        end else begin
            res.value   = heap_mem[1];
            heap_mem[1] = heap_mem[heap_size];
            heap_size--;
            pos     = 1;
            settled = 1'b0;
            // left child wins ties
            while (!settled) begin
                best = pos;
                if (2 * pos <= heap_size && heap_mem[2 * pos] < heap_mem[best])
                    best = 2 * pos;
                if (2 * pos + 1 <= heap_size && heap_mem[2 * pos + 1] < heap_mem[best])
                    best = 2 * pos + 1;
                if (best == pos) begin
                    settled = 1'b1;
                end else begin
                    tmp            = heap_mem[best];
                    heap_mem[best] = heap_mem[pos];
                    heap_mem[pos]  = tmp;
                    pos            = best;
                end
            end
        end
        res.occupancy = OCC_W'(heap_size);
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        hpq_result_t got;
        hpq_result_t want;
        if (!aresetn) begin
            heap_size = 0;
            awaited_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.value     = m_tdata[31:0];
                got.occupancy = m_tdata[39:32];
                got.status    = hpq_status_t'(m_tuser);
                if (awaited_q.size() == 0) begin
                    fail_tally++;
                    $display("%0t: result with nothing expected: value %0d status %0d occupancy %0d",
                             $time, got.value, got.status, got.occupancy);
                end else begin
                    want = awaited_q.pop_front();
                    if (got.value !== want.value) begin
                        fail_tally++;
                        $display("%0t: result_value expected %0d got %0d",
                                 $time, want.value, got.value);
                    end
                    if (got.status !== want.status) begin
                        fail_tally++;
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.occupancy !== want.occupancy) begin
                        fail_tally++;
                        $display("%0t: occupancy expected %0d got %0d",
                                 $time, want.occupancy, got.occupancy);
                    end
                end
            end
            if (s_tvalid && s_tready)
                awaited_q.push_back(apply_request(hpq_cmd_t'(s_tuser), s_tdata));
        end
        mismatch_count <= fail_tally;
        outstanding    <= awaited_q.size();
    end

endmodule

// ===== dv/tb_min_heap_priority_queue.sv =====
// top of the min-heap priority queue testbench: clock, reset, request stimulus with
// bursty sender and stalling receiver, verdict; depends on hpq_pkg, hpq_result_checker
// and the min_heap_priority_queue rtl
module tb_min_heap_priority_queue;
    import hpq_pkg::*;

    localparam int ITEM_TARGET = 1700;
    localparam int CYCLE_LIMIT = 600000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // [31:0] value
    logic        s_tuser;    // [0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // [31:0] result_value, [39:32] occupancy
    logic [1:0]  m_tuser;    // [1:0] status

    int mismatch_count;
    int outstanding;
    int sent_total = 0;
    int burst_left = 1;
    int cycle_count = 0;

    min_heap_priority_queue u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    hpq_result_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // mix of ties, extremes and full-range values
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0, 1:    v = 32'($signed($urandom_range(0, 8)) - 4);
            2: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h7fff_ffff;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h0;
                    default: v = 32'hffff_ffff;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // offers a request until an edge takes it; at a burst end, idles with s_tvalid low
    task automatic send_request(input hpq_cmd_t cmd, input logic [31:0] val);
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_total++;
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
    endtask

    // receiver: one long hold-off first so the block backs up, then mixed stall patterns
    initial begin
        int span;
        int mode;
        m_tready = 1'b0;
        while (!aresetn) @(posedge aclk);
        repeat (400) @(posedge aclk);
        forever begin
            mode = $urandom_range(0, 19);
            span = $urandom_range(5, 60);
            if (mode == 19) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(100, 300)) @(posedge aclk);
            end else begin
                repeat (span) begin
                    if (mode < 9)
                        m_tready <= 1'b1;
                    else if (mode < 15)
                        m_tready <= $urandom_range(0, 1);
                    else
                        m_tready <= ($urandom_range(0, 3) == 0);
                    @(posedge aclk);
                end
            end
        end
    end

    initial begin
        int kind;
        int span;
        int insert_pct;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_INSERT;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        burst_left = $urandom_range(1, 12);

        // directed: empty extract, extremes, equal values, alternating bits, drain past empty
        send_request(CMD_EXTRACT, 32'hffff_ffff);
        send_request(CMD_INSERT, 32'h0);
        send_request(CMD_INSERT, 32'h7fff_ffff);
        send_request(CMD_INSERT, 32'h8000_0000);
        send_request(CMD_INSERT, 32'hffff_ffff);
        send_request(CMD_INSERT, 32'd5);
        send_request(CMD_INSERT, 32'd5);
        send_request(CMD_INSERT, 32'd1);
        send_request(CMD_INSERT, 32'd5);
        send_request(CMD_INSERT, 32'hffff_ffff);
        send_request(CMD_INSERT, 32'haaaa_aaaa);
        send_request(CMD_INSERT, 32'h5555_5555);
        repeat (12) send_request(CMD_EXTRACT, $urandom);

        // fill past capacity so inserts into a full queue occur
        repeat (HPQ_CAPACITY + 12) send_request(CMD_INSERT, pick_value());

        while (sent_total < ITEM_TARGET) begin
            kind = $urandom_range(0, 3);
            span = $urandom_range(10, 160);
            case (kind)
                0:       insert_pct = 90;
                1:       insert_pct = 10;
                default: insert_pct = 50;
            endcase
            repeat (span) begin
                if ($urandom_range(1, 100) <= insert_pct)
                    send_request(CMD_INSERT, pick_value());
                else
                    send_request(CMD_EXTRACT, $urandom);
            end
        end
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (outstanding != 0);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/hpq_pkg.sv
rtl/hpq_cell.sv
rtl/min_heap_priority_queue.sv
dv/hpq_result_checker.sv
dv/tb_min_heap_priority_queue.sv
